>>> src/http_chunked_body_decoder_core_defines.svh
// ----------------------------------------------------------------------------
// HTTP chunked body decoder assertion macros
// Shared property wrappers used by the core's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_CORE_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define HCBD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hcbd assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define HCBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hcbd assertion failed");

`endif

>>> src/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// HTTP chunked body decoder package
// Shared constants, types and the byte classifier function.
// ----------------------------------------------------------------------------
package hcbd_pkg;

   localparam int SIZE_BITS_DEFAULT   = 32;
   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam int TOTAL_W             = 32;

   localparam logic [TOTAL_W-1:0] MAX_BODY_RESET = 32'd1048576;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   typedef enum logic [2:0] {
      PH_SIZE     = 3'd0,
      PH_SIZE_LF  = 3'd1,
      PH_DATA     = 3'd2,
      PH_DATA_CR  = 3'd3,
      PH_DATA_LF  = 3'd4,
      PH_TRAIL_CR = 3'd5,
      PH_TRAIL_LF = 3'd6,
      PH_DONE     = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_SIZE     = 3'd1,
      ERR_OVERFLOW = 3'd2,
      ERR_LENGTH   = 3'd3,
      ERR_TOOBIG   = 3'd4
   } error_type;

   typedef enum logic [1:0] {
      ST_BUSY  = 2'd0,
      ST_DONE  = 2'd1,
      ST_ERROR = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       new_body;
      logic       is_hex;
      logic [3:0] hex_val;
      logic       is_cr;
      logic       is_lf;
   } byte_class_type;

   function automatic byte_class_type classify_byte(logic [7:0] c, logic start);
      byte_class_type r;
      r.data_byte  = c;
      r.new_body   = start;
      r.is_cr      = (c == CH_CR);
      r.is_lf      = (c == CH_LF);
      r.is_hex     = 1'b0;
      r.hex_val    = c[3:0];
      if (c inside {[8'h30:8'h39]}) begin
         r.is_hex = 1'b1;
      end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         r.is_hex  = 1'b1;
         r.hex_val = c[3:0] + 4'd9;
      end
      return r;
   endfunction

endpackage

>>> src/hcbd_if.sv
// ----------------------------------------------------------------------------
// HTTP chunked body decoder channel interfaces
// Valid/ready channels for raw body bytes and for decoded results.
// ----------------------------------------------------------------------------
interface hcbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       new_body;

   modport source (output valid, output data_byte, output new_body, input ready);
   modport sink (input valid, input data_byte, input new_body, output ready);
endinterface

interface hcbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] body_byte;
   logic       body_valid;
   logic [1:0] status;
   logic [2:0] error_kind;

   modport source (output valid, output body_byte, output body_valid, output status,
                   output error_kind, input ready);
   modport sink (input valid, input body_byte, input body_valid, input status,
                 input error_kind, output ready);
endinterface

>>> src/hcbd_front.sv
// ----------------------------------------------------------------------------
// HTTP chunked body decoder front end
// Accepts raw bytes and tags each with its hex value and line-end class.
// ----------------------------------------------------------------------------
module hcbd_front
   import hcbd_pkg::*;
(
   hcbd_req_if.sink       req_ch,
   output logic           push_valid,
   output byte_class_type push_item,
   input  logic           push_ready
);

   assign req_ch.ready = push_ready;
   assign push_valid   = req_ch.valid;
   assign push_item    = classify_byte(req_ch.data_byte, req_ch.new_body);

endmodule

>>> src/hcbd_queue.sv
// ----------------------------------------------------------------------------
// HTTP chunked body decoder queue
// Short FIFO of classified bytes between the front end and the parser.
// ----------------------------------------------------------------------------
module hcbd_queue
   import hcbd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   input  byte_class_type push_item,
   output logic           push_ready,
   output logic           pop_valid,
   output byte_class_type pop_item,
   input  logic           pop_ready
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   byte_class_type   entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> src/hcbd_back.sv
// ----------------------------------------------------------------------------
// HTTP chunked body decoder back end
// Chunk parser state machine with a registered result stage.
// ----------------------------------------------------------------------------
module hcbd_back
   import hcbd_pkg::*;
#(
   parameter int SIZE_BITS = SIZE_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  byte_class_type     item,
   output logic               item_pop,
   input  logic [TOTAL_W-1:0] max_body,
   hcbd_rsp_if.source         rsp_ch
);

   localparam logic [SIZE_BITS-1:0] REM_ONE = {{(SIZE_BITS-1){1'b0}}, 1'b1};

   phase_type              phase_ff, phase_in, phase_cur;
   error_type              err_ff, err_in, err_cur;
   logic [SIZE_BITS-1:0]   rem_ff, rem_in, rem_cur;
   logic [TOTAL_W-1:0]     total_ff, total_in, total_cur;
   logic                   digit_ff, digit_in, digit_cur;
   logic                   active, overflow, take_byte, out_free;

   logic                   rsp_valid_ff;
   logic [7:0]             body_byte_ff, body_byte_in;
   logic                   body_valid_ff, body_valid_in;
   status_type             status_ff, status_in;
   error_type              error_kind_ff;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign item_pop = item_valid && out_free;

   always_comb begin
      phase_cur = item.new_body ? PH_SIZE  : phase_ff;
      err_cur   = item.new_body ? ERR_NONE : err_ff;
      rem_cur   = item.new_body ? '0       : rem_ff;
      total_cur = item.new_body ? '0       : total_ff;
      digit_cur = item.new_body ? 1'b0     : digit_ff;
   end

   assign active    = (err_cur == ERR_NONE) && (phase_cur != PH_DONE);
   assign overflow  = (rem_cur[SIZE_BITS-1 -: 4] != 4'd0);
   assign take_byte = (total_cur < max_body);

   always_comb begin
      phase_in = phase_cur;
      if (active) begin
         case (phase_cur)
            PH_SIZE: begin
               if (!item.is_hex && item.is_cr && digit_cur) begin
                  phase_in = PH_SIZE_LF;
               end
            end
            PH_SIZE_LF: begin
               if (item.is_lf) begin
                  phase_in = (rem_cur == '0) ? PH_TRAIL_CR : PH_DATA;
               end
            end
            PH_DATA: begin
               if (take_byte && rem_cur == REM_ONE) begin
                  phase_in = PH_DATA_CR;
               end
            end
            PH_DATA_CR: begin
               if (item.is_cr) begin
                  phase_in = PH_DATA_LF;
               end
            end
            PH_DATA_LF: begin
               if (item.is_lf) begin
                  phase_in = PH_SIZE;
               end
            end
            PH_TRAIL_CR: begin
               if (item.is_cr) begin
                  phase_in = PH_TRAIL_LF;
               end
            end
            PH_TRAIL_LF: begin
               if (item.is_lf) begin
                  phase_in = PH_DONE;
               end
            end
            default: begin
               phase_in = phase_cur;
            end
         endcase
      end
   end

   always_comb begin
      err_in        = err_cur;
      rem_in        = rem_cur;
      total_in      = total_cur;
      digit_in      = digit_cur;
      body_valid_in = 1'b0;
      if (active) begin
         case (phase_cur)
            PH_SIZE: begin
               if (item.is_hex) begin
                  if (overflow) begin
                     err_in = ERR_OVERFLOW;
                  end else begin
                     rem_in   = {rem_cur[SIZE_BITS-5:0], item.hex_val};
                     digit_in = 1'b1;
                  end
               end else if (!(item.is_cr && digit_cur)) begin
                  err_in = ERR_SIZE;
               end
            end
            PH_SIZE_LF: begin
               if (!item.is_lf) begin
                  err_in = ERR_SIZE;
               end
            end
            PH_DATA: begin
               if (!take_byte) begin
                  err_in = ERR_TOOBIG;
               end else begin
                  body_valid_in = 1'b1;
                  total_in      = total_cur + 1'b1;
                  rem_in        = rem_cur - 1'b1;
               end
            end
            PH_DATA_CR: begin
               if (!item.is_cr) begin
                  err_in = ERR_LENGTH;
               end
            end
            PH_DATA_LF: begin
               if (item.is_lf) begin
                  digit_in = 1'b0;
                  rem_in   = '0;
               end else begin
                  err_in = ERR_LENGTH;
               end
            end
            PH_TRAIL_CR, PH_TRAIL_LF: begin
               if (!(item.is_cr && phase_cur == PH_TRAIL_CR) &&
                   !(item.is_lf && phase_cur == PH_TRAIL_LF)) begin
                  err_in = ERR_SIZE;
               end
            end
            default: begin
               err_in = err_cur;
            end
         endcase
      end
      body_byte_in = body_valid_in ? item.data_byte : 8'd0;
      if (err_in != ERR_NONE) begin
         status_in = ST_ERROR;
      end else if (phase_in == PH_DONE) begin
         status_in = ST_DONE;
      end else begin
         status_in = ST_BUSY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SIZE;
         err_ff       <= ERR_NONE;
         rem_ff       <= '0;
         total_ff     <= '0;
         digit_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (item_pop) begin
            phase_ff <= phase_in;
            err_ff   <= err_in;
            rem_ff   <= rem_in;
            total_ff <= total_in;
            digit_ff <= digit_in;
         end
         if (out_free) begin
            rsp_valid_ff <= item_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         body_byte_ff  <= body_byte_in;
         body_valid_ff <= body_valid_in;
         status_ff     <= status_in;
         error_kind_ff <= err_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.body_byte  = body_byte_ff;
   assign rsp_ch.body_valid = body_valid_ff;
   assign rsp_ch.status     = status_ff;
   assign rsp_ch.error_kind = error_kind_ff;

endmodule

>>> src/http_chunked_body_decoder_core.sv
// ----------------------------------------------------------------------------
// HTTP chunked body decoder core
// Decodes an HTTP/1.1 chunked transfer body one raw byte per transaction.
// ----------------------------------------------------------------------------
// Raw body bytes enter on req_ch, with new_body marking the first byte of a
// new body. Every accepted transaction produces exactly one result transaction
// on rsp_ch carrying the payload byte (when body_valid is set), the body status
// and the error kind. Completion and error are sticky until new_body.
// The csr_wr_en/csr_wr_data port sets the maximum total body length; the
// user must write it only while the core is idle; the core does not enforce it.
// An accepted byte is written into the queue, then popped by the back end,
// whose output register makes its result valid. One byte is accepted per
// cycle while the receiver takes results: the front end only classifies the
// byte, and the back-end parser updates its counters as it pops each byte.
// Reset clears the queue, the parser state and the output stage, and loads
// the maximum body length with its default of 1 MiB.
// When the receiver stalls, the result holds in the output register, the
// queue absorbs up to QUEUE_DEPTH further bytes, and then req_ch.ready drops.
// ----------------------------------------------------------------------------
`include "http_chunked_body_decoder_core_defines.svh"

module http_chunked_body_decoder_core
   import hcbd_pkg::*;
#(
   parameter int SIZE_BITS   = SIZE_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   hcbd_req_if.sink           req_ch,
   hcbd_rsp_if.source         rsp_ch,
   input  logic               csr_wr_en,
   input  logic [TOTAL_W-1:0] csr_wr_data
);

   logic               max_body_en;
   logic [TOTAL_W-1:0] max_body_ff, max_body_in;
   logic               push_valid, push_ready;
   byte_class_type     push_item;
   logic               pop_valid, pop_ready;
   byte_class_type     pop_item;

   assign max_body_en = csr_wr_en;
   assign max_body_in = csr_wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_body_ff <= MAX_BODY_RESET;
      end else if (max_body_en) begin
         max_body_ff <= max_body_in;
      end
   end

   hcbd_front u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   hcbd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   hcbd_back #(
      .SIZE_BITS (SIZE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (pop_valid),
      .item       (pop_item),
      .item_pop   (pop_ready),
      .max_body   (max_body_ff),
      .rsp_ch     (rsp_ch)
   );

   `HCBD_ASSERT_SAME(a_payload_only_busy, clock, reset,
      rsp_ch.valid && rsp_ch.body_valid,
      rsp_ch.status == ST_BUSY && rsp_ch.error_kind == ERR_NONE)
   `HCBD_ASSERT_SAME(a_error_kind_matches, clock, reset,
      rsp_ch.valid, (rsp_ch.status == ST_ERROR) == (rsp_ch.error_kind != ERR_NONE))
   `HCBD_ASSERT_SAME(a_idle_byte_zero, clock, reset,
      rsp_ch.valid && !rsp_ch.body_valid, rsp_ch.body_byte == 8'd0)
   `HCBD_ASSERT_NEXT(a_result_follows_pop, clock, reset,
      pop_valid && pop_ready, rsp_ch.valid)

endmodule
